### rtl/cwmb_pkg.sv
// Shared constants, codes and interface types of the cross window mean blur.
`timescale 1ns / 1ps

package cwmb_pkg;

    localparam int MAX_RADIUS = 8;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int RING_ROWS = 2 * MAX_RADIUS + 1;
    localparam int RING_W    = $clog2(RING_ROWS);
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WID_W     = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W     = $clog2(MAX_HEIGHT + 1);
    localparam int RAD_W     = $clog2(MAX_RADIUS + 1);
    localparam int ADDR_W    = RING_W + COL_W;
    localparam int MEM_DEPTH = RING_ROWS * MAX_WIDTH;
    localparam int MAX_TAPS  = 4 * MAX_RADIUS + 1;
    localparam int CNT_W     = $clog2(MAX_TAPS + 1);
    localparam int SUM_W     = $clog2(255 * MAX_TAPS + 1);
    localparam int DIVC_W    = $clog2(SUM_W);
    localparam int PIX_W     = 24;

    localparam int CFG_RADIUS_W = 4;
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [1:0] {
        DIR_UP, DIR_DOWN, DIR_LEFT, DIR_RIGHT
    } dir_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CHECK, ST_TAP, ST_FLUSH, ST_DIV, ST_OUT
    } state_t;

    typedef struct packed {
        logic             accept;
        logic             acc_clear;
        logic             tap_issue;
        logic             tap_center;
        logic [RAD_W-1:0] tap_a;
        dir_t             tap_dir;
        logic             div_step;
        logic             out_load;
    } cwmb_cmd_t;

    typedef struct packed {
        logic             result_ready;
        logic             out_free;
        logic [RAD_W-1:0] r_eff;
    } cwmb_status_t;

endpackage

### rtl/cwmb_ctrl.sv
// Controller state machine: sequences the pixel write, window taps and division.
`timescale 1ns / 1ps

module cwmb_ctrl
    import cwmb_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  cwmb_status_t status,
    output cwmb_cmd_t    cmd
);

    state_t            state_reg, state_next;
    logic [RAD_W-1:0]  a_reg, a_next;
    dir_t              dir_reg, dir_next;
    logic [DIVC_W-1:0] divc_reg, divc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            a_reg     <= '0;
            dir_reg   <= DIR_UP;
            divc_reg  <= '0;
        end else begin
            state_reg <= state_next;
            a_reg     <= a_next;
            dir_reg   <= dir_next;
            divc_reg  <= divc_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        a_next         = a_reg;
        dir_next       = dir_reg;
        divc_next      = divc_reg;
        cmd            = '0;
        cmd.tap_a      = a_reg;
        cmd.tap_dir    = dir_reg;
        cmd.tap_center = (a_reg == '0);
        s_axis_tready  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.result_ready) begin
                    cmd.acc_clear = 1'b1;
                    a_next        = '0;
                    dir_next      = DIR_UP;
                    state_next    = ST_TAP;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_TAP: begin
                cmd.tap_issue = 1'b1;
                if (a_reg == '0) begin
                    if (status.r_eff == '0) begin
                        state_next = ST_FLUSH;
                    end else begin
                        a_next   = RAD_W'(1);
                        dir_next = DIR_UP;
                    end
                end else if (dir_reg == DIR_RIGHT) begin
                    dir_next = DIR_UP;
                    if (a_reg == status.r_eff) begin
                        state_next = ST_FLUSH;
                    end else begin
                        a_next = a_reg + RAD_W'(1);
                    end
                end else begin
                    dir_next = dir_t'(dir_reg + 2'd1);
                end
            end
            ST_FLUSH: begin
                divc_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                divc_next    = divc_reg + DIVC_W'(1);
                if (divc_reg == DIVC_W'(SUM_W - 1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/cwmb_datapath.sv
// Datapath: line store, position counters, window accumulation, divider, output register.
`timescale 1ns / 1ps

module cwmb_datapath
    import cwmb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cwmb_cmd_t             cmd,
    output cwmb_status_t          status,
    input  logic                  s_axis_tuser,
    input  logic [PIX_W-1:0]      s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [PIX_W-1:0]      m_axis_tdata,
    output logic                  m_axis_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [PIX_W-1:0] mem [0:MEM_DEPTH-1];

    logic [CFG_RADIUS_W-1:0] radius_reg;
    logic [CFG_WIDTH_W-1:0]  width_reg;
    logic [CFG_HEIGHT_W-1:0] height_reg;

    logic [ROW_W-1:0]  in_row_reg, out_row_reg;
    logic [COL_W-1:0]  in_col_reg, out_col_reg;
    logic [RING_W-1:0] in_ring_reg, out_ring_reg;

    logic [PIX_W-1:0] rd_data_reg;
    logic             tap_q_reg;
    logic [SUM_W-1:0] acc_reg [0:2];
    logic [CNT_W-1:0] rem_reg [0:2];
    logic [CNT_W-1:0] cnt_reg;
    logic             m_valid_reg;
    logic [PIX_W-1:0] m_data_reg;
    logic             m_last_reg;

    logic [RAD_W-1:0]  r_eff;
    logic [WID_W-1:0]  w_eff, wm1;
    logic [ROW_W-1:0]  h_eff, hm1;
    logic [ROW_W:0]    lr_sum;
    logic [ROW_W-1:0]  last_row;
    logic [WID_W:0]    lc_sum;
    logic [WID_W-1:0]  last_col, need_col;
    logic              ready;
    logic              in_open, restart, frame_end;
    logic [RING_W:0]   up_ring, dn_ring;
    logic [RING_W-1:0] tap_ring;
    logic [COL_W-1:0]  tap_col;
    logic              tap_ok;
    logic [ADDR_W-1:0] wr_addr, rd_addr;

    assign r_eff = (int'(radius_reg) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(radius_reg);
    assign w_eff = (width_reg == '0) ? WID_W'(1) :
                   (int'(width_reg) > MAX_WIDTH) ? WID_W'(MAX_WIDTH) : WID_W'(width_reg);
    assign h_eff = (height_reg == '0) ? ROW_W'(1) :
                   (int'(height_reg) > MAX_HEIGHT) ? ROW_W'(MAX_HEIGHT) : ROW_W'(height_reg);
    assign wm1 = w_eff - WID_W'(1);
    assign hm1 = h_eff - ROW_W'(1);

    // Readiness: the bottom arm end and the right arm end must both have arrived.
    assign lr_sum   = (ROW_W+1)'(out_row_reg) + (ROW_W+1)'(r_eff);
    assign last_row = (lr_sum > (ROW_W+1)'(hm1)) ? hm1 : lr_sum[ROW_W-1:0];
    assign lc_sum   = (WID_W+1)'(out_col_reg) + (WID_W+1)'(r_eff);
    assign last_col = (lc_sum > (WID_W+1)'(wm1)) ? wm1 : lc_sum[WID_W-1:0];
    assign need_col = (last_row > out_row_reg) ? WID_W'(out_col_reg) : last_col;
    assign ready    = (out_row_reg < h_eff) &&
                      ((in_row_reg > last_row) ||
                       ((in_row_reg == last_row) && (WID_W'(in_col_reg) > need_col)));

    assign in_open   = (in_row_reg < h_eff);
    assign restart   = cfg_valid && (cfg_index == REG_RADIUS || cfg_index == REG_WIDTH ||
                                     cfg_index == REG_HEIGHT);
    assign frame_end = (out_row_reg == hm1) && (WID_W'(out_col_reg) == wm1);

    always_comb begin
        up_ring = (out_ring_reg >= RING_W'(cmd.tap_a)) ?
                  (RING_W+1)'(out_ring_reg) - (RING_W+1)'(cmd.tap_a) :
                  (RING_W+1)'(out_ring_reg) + (RING_W+1)'(RING_ROWS) - (RING_W+1)'(cmd.tap_a);
        dn_ring = (RING_W+1)'(out_ring_reg) + (RING_W+1)'(cmd.tap_a);
        if (dn_ring >= (RING_W+1)'(RING_ROWS)) begin
            dn_ring = dn_ring - (RING_W+1)'(RING_ROWS);
        end
        tap_ring = out_ring_reg;
        tap_col  = out_col_reg;
        tap_ok   = 1'b1;
        if (!cmd.tap_center) begin
            case (cmd.tap_dir)
                DIR_UP: begin
                    tap_ring = up_ring[RING_W-1:0];
                    tap_ok   = (out_row_reg >= ROW_W'(cmd.tap_a));
                end
                DIR_DOWN: begin
                    tap_ring = dn_ring[RING_W-1:0];
                    tap_ok   = ((ROW_W+1)'(out_row_reg) + (ROW_W+1)'(cmd.tap_a)) <
                               (ROW_W+1)'(h_eff);
                end
                DIR_LEFT: begin
                    tap_col = out_col_reg - COL_W'(cmd.tap_a);
                    tap_ok  = (out_col_reg >= COL_W'(cmd.tap_a));
                end
                DIR_RIGHT: begin
                    tap_col = out_col_reg + COL_W'(cmd.tap_a);
                    tap_ok  = ((WID_W+1)'(out_col_reg) + (WID_W+1)'(cmd.tap_a)) <
                              (WID_W+1)'(w_eff);
                end
                default: begin
                    tap_ok = 1'b0;
                end
            endcase
        end
    end

    assign wr_addr = ADDR_W'(in_ring_reg * MAX_WIDTH) + ADDR_W'(in_col_reg);
    assign rd_addr = ADDR_W'(tap_ring * MAX_WIDTH) + ADDR_W'(tap_col);

    always_ff @(posedge aclk) begin
        if (cmd.accept && s_axis_tuser == OP_PIXEL && in_open) begin
            mem[wr_addr] <= s_axis_tdata;
        end
        if (cmd.tap_issue) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Registers and frame position counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg   <= CFG_RADIUS_W'(1);
            width_reg    <= CFG_WIDTH_W'(640);
            height_reg   <= CFG_HEIGHT_W'(480);
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_ring_reg  <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_ring_reg <= '0;
        end else if (restart) begin
            case (cfg_index)
                REG_RADIUS: radius_reg <= cfg_data[CFG_RADIUS_W-1:0];
                REG_WIDTH:  width_reg  <= cfg_data[CFG_WIDTH_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[CFG_HEIGHT_W-1:0];
                default:    radius_reg <= radius_reg;
            endcase
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_ring_reg  <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_ring_reg <= '0;
        end else begin
            if (cmd.accept && s_axis_tuser == OP_PIXEL && in_open) begin
                if (WID_W'(in_col_reg) + WID_W'(1) >= w_eff) begin
                    in_col_reg  <= '0;
                    in_row_reg  <= in_row_reg + ROW_W'(1);
                    in_ring_reg <= (in_ring_reg == RING_W'(RING_ROWS - 1)) ?
                                   '0 : in_ring_reg + RING_W'(1);
                end else begin
                    in_col_reg <= in_col_reg + COL_W'(1);
                end
            end
            if (cmd.out_load) begin
                if (frame_end) begin
                    in_row_reg   <= '0;
                    in_col_reg   <= '0;
                    in_ring_reg  <= '0;
                    out_row_reg  <= '0;
                    out_col_reg  <= '0;
                    out_ring_reg <= '0;
                end else if (WID_W'(out_col_reg) == wm1) begin
                    out_col_reg  <= '0;
                    out_row_reg  <= out_row_reg + ROW_W'(1);
                    out_ring_reg <= (out_ring_reg == RING_W'(RING_ROWS - 1)) ?
                                    '0 : out_ring_reg + RING_W'(1);
                end else begin
                    out_col_reg <= out_col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_q_reg <= 1'b0;
        end else begin
            tap_q_reg <= cmd.tap_issue && tap_ok;
        end
    end

    // Accumulate, then restoring division; the quotient shifts into the sum register.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.acc_clear) begin
            cnt_reg <= '0;
            for (int c = 0; c < 3; c++) begin
                acc_reg[c] <= '0;
                rem_reg[c] <= '0;
            end
        end else if (tap_q_reg) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            for (int c = 0; c < 3; c++) begin
                acc_reg[c] <= acc_reg[c] + SUM_W'(rd_data_reg[8*c +: 8]);
            end
        end else if (cmd.div_step) begin
            for (int c = 0; c < 3; c++) begin
                if ({rem_reg[c], acc_reg[c][SUM_W-1]} >= (CNT_W+1)'(cnt_reg)) begin
                    rem_reg[c] <= CNT_W'({rem_reg[c], acc_reg[c][SUM_W-1]} -
                                         (CNT_W+1)'(cnt_reg));
                    acc_reg[c] <= {acc_reg[c][SUM_W-2:0], 1'b1};
                end else begin
                    rem_reg[c] <= CNT_W'({rem_reg[c], acc_reg[c][SUM_W-1]});
                    acc_reg[c] <= {acc_reg[c][SUM_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= {acc_reg[2][7:0], acc_reg[1][7:0], acc_reg[0][7:0]};
            m_last_reg <= frame_end;
        end
    end

    assign m_axis_tvalid       = m_valid_reg;
    assign m_axis_tdata        = m_data_reg;
    assign m_axis_tlast        = m_last_reg;
    assign cfg_ready           = 1'b1;
    assign status.result_ready = ready;
    assign status.out_free     = !m_valid_reg || m_axis_tready;
    assign status.r_eff        = r_eff;

`ifndef SYNTHESIS
    a_tap_count: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(cnt_reg) <= MAX_TAPS)
        else $error("window tap count above the largest window");
    a_in_col: assert property (@(posedge aclk) disable iff (!aresetn)
        WID_W'(in_col_reg) < w_eff)
        else $error("input column outside the row");
    a_out_row: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> out_row_reg < h_eff)
        else $error("result produced beyond the last row");
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_axis_tready))
        else $error("output register overwritten while a beat waits");
`endif

endmodule

### rtl/cross_window_mean_blur.sv
// Top level of the cross window mean blur: joins the controller and the datapath.
`timescale 1ns / 1ps

// Plus-shaped mean filter over a raster stream of 24-bit BGR pixels. Each result
// pixel is the per-channel truncating mean of the center pixel and of the pixels up
// to radius steps above, below, left and right; neighbors outside the frame are left
// out of both the sum and the count. Results follow the input about radius rows late,
// so after the last pixel of a frame the source sends drain beats (tuser = 1), each
// of which releases at most one pending result; tlast marks the last result of a
// frame, after which the next pixel starts a new frame. Pixels that arrive after a
// full frame are dropped. The block takes one beat at a time: a beat that yields no
// result passes through the accept and the readiness check only, and one that yields
// a result goes on through 4*radius + 1 window taps via the single read port of the
// line store (one tap per cycle), a flush of the last tap into the sums, 14 steps of
// the bit-serial divider (one quotient bit per cycle) and a load of the output, which
// waits until the output register is free. The next beat is taken while a finished
// result still waits in the output register. A configuration write to the radius,
// width or height register restarts the frame and must only be issued while the
// block is idle.
module cross_window_mean_blur
    import cwmb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [PIX_W-1:0]      s_axis_tdata,   // blue_in, green_in, red_in
    input  logic                  s_axis_tuser,   // operation
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [PIX_W-1:0]      m_axis_tdata,   // blue_out, green_out, red_out
    output logic                  m_axis_tlast,   // frame_done
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cwmb_cmd_t    cmd;
    cwmb_status_t status;

    // The controller walks each accepted beat through write, tap reads and division.
    cwmb_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    // The datapath holds the line store, positions, sums and the output register.
    cwmb_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

endmodule

### tb/sv/cross_window_mean_blur_tb.sv
// Self-checking testbench of the cross window mean blur.
`timescale 1ns / 1ps

// The block is driven with whole frames of random or extreme pixels and drain beats.
// A behavioral copy of the filter, kept inside this module, predicts every result
// pixel. The checker compares each result beat, field by field, with the oldest
// prediction. Frames are kept small so that every result can come out within the run.
// Both stream sides idle at random, and one phase holds the receiver off for a long
// stretch so that the block fills up and stalls its input.
module cross_window_mean_blur_tb;
    import cwmb_pkg::*;

    typedef struct {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       frame_done;
    } blur_px_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [PIX_W-1:0]      s_axis_tdata = '0;
    logic                  s_axis_tuser = OP_PIXEL;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [PIX_W-1:0]      m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_RADIUS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    cross_window_mean_blur dut (.*);

    always #1 aclk = ~aclk;

    // Shadow of the block: line ring, frame counters and register copies.
    logic [PIX_W-1:0] ring_px [RING_ROWS*MAX_WIDTH];
    int unsigned in_row, in_col, out_row, out_col;
    logic [CFG_RADIUS_W-1:0] radius_reg;
    logic [CFG_WIDTH_W-1:0]  width_reg;
    logic [CFG_HEIGHT_W-1:0] height_reg;

    blur_px_t    pending_px[$];
    int          mismatches = 0;
    int          beats_sent = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    bit          rx_hold = 1'b0;

    function automatic int unsigned ring_addr(int unsigned row, int unsigned col);
        return (row % RING_ROWS) * MAX_WIDTH + (col % MAX_WIDTH);
    endfunction

    function automatic void add_tap(input logic [PIX_W-1:0] p, inout int unsigned sb,
                                    inout int unsigned sg, inout int unsigned sr,
                                    inout int unsigned n);
        sb += p[7:0];
        sg += p[15:8];
        sr += p[23:16];
        n++;
    endfunction

    // Advances the shadow by one accepted beat; returns 1 when a result pixel is due.
    function automatic bit blur_predict(input logic op, input logic [PIX_W-1:0] px,
                                        output blur_px_t res);
        int unsigned w, h, r, rcvd, lrow, lcol, need, a;
        int unsigned sb, sg, sr, n;
        w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
        h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg);
        r = (radius_reg > MAX_RADIUS) ? MAX_RADIUS : radius_reg;
        // Pixels after a complete frame are dropped.
        if (op == OP_PIXEL && in_row < h) begin
            ring_px[ring_addr(in_row, in_col)] = px;
            if (++in_col >= w) begin
                in_col = 0;
                in_row++;
            end
        end
        if (out_row >= h) return 1'b0;
        rcvd = in_row * w + in_col;
        lrow = (out_row + r > h - 1) ? h - 1 : out_row + r;
        lcol = (out_col + r > w - 1) ? w - 1 : out_col + r;
        need = lrow * w + out_col;
        if (out_row * w + lcol > need) need = out_row * w + lcol;
        if (rcvd <= need) return 1'b0;
        sb = 0; sg = 0; sr = 0; n = 0;
        add_tap(ring_px[ring_addr(out_row, out_col)], sb, sg, sr, n);
        for (a = 1; a <= r; a++) begin
            if (out_row >= a) add_tap(ring_px[ring_addr(out_row - a, out_col)], sb, sg, sr, n);
            if (out_row + a < h) add_tap(ring_px[ring_addr(out_row + a, out_col)], sb, sg, sr, n);
            if (out_col >= a) add_tap(ring_px[ring_addr(out_row, out_col - a)], sb, sg, sr, n);
            if (out_col + a < w) add_tap(ring_px[ring_addr(out_row, out_col + a)], sb, sg, sr, n);
        end
        res.blue = 8'(sb / n);
        res.green = 8'(sg / n);
        res.red = 8'(sr / n);
        res.frame_done = (out_row == h - 1) && (out_col == w - 1);
        if (res.frame_done) begin
            in_row = 0; in_col = 0; out_row = 0; out_col = 0;
        end else if (++out_col >= w) begin
            out_col = 0;
            out_row++;
        end
        return 1'b1;
    endfunction

    // Sends one beat, with a random gap before it, and records the predicted result.
    task automatic send_beat(input logic op, input logic [PIX_W-1:0] px);
        blur_px_t res;
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= px;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        beats_sent++;
        if (blur_predict(op, px, res)) pending_px.push_back(res);
    endtask

    // Waits until all predicted results have come and the block has gone quiet.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_px.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        // Any known register restarts the frame; unknown indexes are ignored.
        if (idx == REG_RADIUS) radius_reg = value[CFG_RADIUS_W-1:0];
        else if (idx == REG_WIDTH) width_reg = value[CFG_WIDTH_W-1:0];
        else if (idx == REG_HEIGHT) height_reg = value[CFG_HEIGHT_W-1:0];
        else return;
        in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    endtask

    task automatic set_frame(input int r, input int w, input int h);
        write_reg(REG_RADIUS, CFG_DATA_W'(r));
        write_reg(REG_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_HEIGHT, CFG_DATA_W'(h));
    endtask

    // Pixel style: 0 random, 1 all zero, 2 all ones, 3 alternating extremes.
    function automatic logic [PIX_W-1:0] make_px(input int style, input int k);
        case (style)
            1: return '0;
            2: return '1;
            3: return k[0] ? 24'hFF00FF : 24'h00FF00;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // Sends one frame, optionally with stray drains and trailing extra pixels, and
    // then drains until the shadow shows the frame finished.
    task automatic run_frame(input int style, input bit noisy);
        int k;
        int total;
        total = ((width_reg == 0) ? 1 : width_reg) * ((height_reg == 0) ? 1 : height_reg);
        for (k = 0; k < total; k++) begin
            if (noisy && $urandom_range(9) == 0) send_beat(OP_DRAIN, PIX_W'($urandom));
            send_beat(OP_PIXEL, make_px(style, k));
        end
        if (noisy && $urandom_range(3) == 0) send_beat(OP_PIXEL, PIX_W'($urandom));
        while (in_row != 0 || in_col != 0 || out_row != 0 || out_col != 0)
            send_beat(OP_DRAIN, PIX_W'($urandom));
    endtask

    // Result checker, with the receiver's random or forced back-pressure.
    always @(posedge aclk) begin
        blur_px_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_px.size() == 0) begin
                $error("unexpected result beat %h", m_axis_tdata);
                mismatches++;
            end else begin
                want = pending_px.pop_front();
                if (m_axis_tdata[7:0] !== want.blue) begin
                    $error("blue_out: expected %0d, got %0d", want.blue, m_axis_tdata[7:0]);
                    mismatches++;
                end
                if (m_axis_tdata[15:8] !== want.green) begin
                    $error("green_out: expected %0d, got %0d", want.green, m_axis_tdata[15:8]);
                    mismatches++;
                end
                if (m_axis_tdata[23:16] !== want.red) begin
                    $error("red_out: expected %0d, got %0d", want.red, m_axis_tdata[23:16]);
                    mismatches++;
                end
                if (m_axis_tlast !== want.frame_done) begin
                    $error("frame_done: expected %0d, got %0d", want.frame_done, m_axis_tlast);
                    mismatches++;
                end
            end
        end
        m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    // Smallest frames, extreme pixels and out-of-range register values.
    task automatic test_extremes();
        set_frame(0, 1, 1);
        run_frame(2, 1'b0);
        set_frame(0, 0, 0);
        run_frame(1, 1'b0);
        // A radius above the maximum acts as the maximum and reaches past every edge.
        set_frame(15, 3, 2);
        run_frame(3, 1'b0);
        set_frame(8, 1, 3);
        run_frame(0, 1'b0);
        // The largest sizes only start a frame, which a later known register write abandons.
        set_frame(1, 2047, 8191);
        send_beat(OP_PIXEL, 24'h123456);
        send_beat(OP_DRAIN, 24'hEDCBA9);
        write_reg(2'd3, '1);
        set_frame(1, 1024, 4096);
        send_beat(OP_PIXEL, '1);
    endtask

    // The receiver stops for a long stretch while a frame keeps streaming in.
    task automatic test_backpressure();
        set_frame(2, 8, 6);
        fork
            begin
                rx_hold = 1'b1;
                repeat (400) @(posedge aclk);
                rx_hold = 1'b0;
            end
        join_none
        run_frame(0, 1'b0);
        wait_idle();
    endtask

    task automatic test_random_frames(input int quota);
        int stop_at;
        int k;
        stop_at = beats_sent + quota;
        while (beats_sent < stop_at) begin
            set_frame($urandom_range(9) == 0 ? $urandom_range(15) : $urandom_range(MAX_RADIUS),
                      $urandom_range(12), $urandom_range(7));
            if ($urandom_range(7) == 0) begin
                // A broken frame: a few pixels, then a restart by the next write.
                for (k = $urandom_range(1, 4); k > 0; k--)
                    send_beat($urandom_range(3) == 0 ? OP_DRAIN : OP_PIXEL, PIX_W'($urandom));
            end else begin
                run_frame($urandom_range(5) < 4 ? 0 : $urandom_range(1, 3), 1'b1);
            end
        end
    endtask

    initial begin
        radius_reg = 4'd1;
        width_reg = 11'd640;
        height_reg = 13'd480;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_backpressure();
        tx_idle_pct = 32;
        rx_idle_pct = 79;
        test_random_frames(180);
        tx_idle_pct = 79;
        rx_idle_pct = 32;
        test_random_frames(180);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_frames(180);
        wait_idle();
        repeat (100) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
